// ----- rtl/core/bezier_arc_length_gauss4_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Bezier arc length core
// Implication checks, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef BEZIER_ARC_LENGTH_GAUSS4_ASSERT_SVH
`define BEZIER_ARC_LENGTH_GAUSS4_ASSERT_SVH

// same-cycle implication, masked during reset
`define BAL4_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, not masked
`define BAL4_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bal4_pkg.sv -----
// ----------------------------------------------------------------------------
// bal4_pkg
// Constants, types and width helpers for the Bezier arc length core.
// ----------------------------------------------------------------------------
`default_nettype none

package bal4_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int NODES           = 4;
   localparam int POINTS          = 4;
   localparam int AXES            = 3;
   localparam int WFRAC           = 24;
   localparam int W_W             = 27;
   localparam int QW_W            = 23;
   localparam int LEN_W           = 32;
   localparam int SQRT_STEPS      = 4;

   typedef logic signed [W_W-1:0] weight_type;

   // Bernstein derivative weights, Q.24, [node][point]
   localparam weight_type BERN_W [NODES][POINTS] = '{
      '{-27'sd22593237,  27'sd336258,    27'sd16775548,  27'sd5481431},
      '{-27'sd5481431,  -27'sd16775548, -27'sd336258,    27'sd22593237},
      '{-27'sd43585048,  27'sd37081085,  27'sd6261325,   27'sd242638},
      '{-27'sd242638,   -27'sd6261325,  -27'sd37081085,  27'sd43585048}
   };

   localparam logic [QW_W-1:0] QW_INNER = 23'd5470590;
   localparam logic [QW_W-1:0] QW_OUTER = 23'd2918018;

   function automatic int mag_w(input int cw);
      return cw + 4;
   endfunction

   function automatic int q_w(input int cw);
      return (mag_w(cw) < 31) ? mag_w(cw) : 31;
   endfunction

   function automatic int s_max(input int cw);
      return mag_w(cw) - q_w(cw);
   endfunction

   function automatic int s_w(input int cw);
      return (s_max(cw) > 0) ? $clog2(s_max(cw) + 1) : 1;
   endfunction

   function automatic int root_w(input int cw);
      return q_w(cw) + 1;
   endfunction

   function automatic int norm_w(input int cw);
      return root_w(cw) + s_max(cw);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bal4_deriv.sv -----
// ----------------------------------------------------------------------------
// bal4_deriv
// Derivative components at the four nodes, magnitudes, range shift and
// sum of squares. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bal4_deriv import bal4_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               adv,
   input  wire logic                               in_valid,
   input  wire logic signed [COORD_WIDTH-1:0]      coord [POINTS][AXES],
   output logic                                    out_valid,
   output logic [2*root_w(COORD_WIDTH)-1:0]        out_sum [NODES],
   output logic [s_w(COORD_WIDTH)-1:0]             out_shift [NODES]
);

   localparam int PR_W  = COORD_WIDTH + W_W;
   localparam int ACC_W = PR_W + 2;
   localparam int MAG_W = mag_w(COORD_WIDTH);
   localparam int Q_W   = q_w(COORD_WIDTH);
   localparam int S_MAX = s_max(COORD_WIDTH);
   localparam int S_W   = s_w(COORD_WIDTH);
   localparam int SUM_W = 2 * root_w(COORD_WIDTH);

   logic [3:0] valid_ff;

   logic signed [PR_W-1:0] prod_ff [NODES][POINTS][AXES];
   logic [MAG_W-1:0]       mag_in  [NODES][AXES];
   logic [MAG_W-1:0]       mag_ff  [NODES][AXES];
   logic [Q_W-1:0]         q_in    [NODES][AXES];
   logic [Q_W-1:0]         q_ff    [NODES][AXES];
   logic [S_W-1:0]         s_in    [NODES];
   logic [S_W-1:0]         s1_ff   [NODES];
   logic [S_W-1:0]         s2_ff   [NODES];
   logic [SUM_W-1:0]       sum_in  [NODES];
   logic [SUM_W-1:0]       sum_ff  [NODES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // stage 1: one product per weight
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < NODES; n++)
            for (int p = 0; p < POINTS; p++)
               for (int a = 0; a < AXES; a++)
                  prod_ff[n][p][a] <= PR_W'(coord[p][a] * BERN_W[n][p]);
      end
   end

   // stage 2: sum, round half up, magnitude
   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] d;
      for (int n = 0; n < NODES; n++) begin
         for (int a = 0; a < AXES; a++) begin
            acc = ACC_W'(prod_ff[n][0][a]) + ACC_W'(prod_ff[n][1][a])
                + ACC_W'(prod_ff[n][2][a]) + ACC_W'(prod_ff[n][3][a])
                + (ACC_W'(1) <<< (WFRAC - 1));
            d = acc >>> WFRAC;
            mag_in[n][a] = d[ACC_W-1] ? MAG_W'(-d) : MAG_W'(d);
         end
      end
   end

   // stage 3: least shift that brings the largest magnitude under 2^31
   always_comb begin
      logic [MAG_W-1:0] m;
      for (int n = 0; n < NODES; n++) begin
         m = mag_ff[n][0] | mag_ff[n][1] | mag_ff[n][2];
         s_in[n] = S_W'(S_MAX);
         for (int k = S_MAX; k >= 0; k--) begin
            if ((m >> (k + 31)) == '0)
               s_in[n] = S_W'(k);
         end
         for (int a = 0; a < AXES; a++)
            q_in[n][a] = Q_W'(mag_ff[n][a] >> s_in[n]);
      end
   end

   // stage 4: sum of squares
   always_comb begin
      for (int n = 0; n < NODES; n++) begin
         sum_in[n] = SUM_W'(q_ff[n][0] * q_ff[n][0]) + SUM_W'(q_ff[n][1] * q_ff[n][1])
                   + SUM_W'(q_ff[n][2] * q_ff[n][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
         q_ff   <= q_in;
         s1_ff  <= s_in;
         s2_ff  <= s1_ff;
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_sum   = sum_ff;
   assign out_shift = s2_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bal4_isqrt.sv -----
// ----------------------------------------------------------------------------
// bal4_isqrt
// Pipelined floor square root, one result bit per step, a few steps per
// register stage. A side word travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module bal4_isqrt import bal4_pkg::*; #(
   parameter int ROOT_W = 29,
   parameter int SIDE_W = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int NSTG  = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic [NSTG-1:0]   valid_ff;
   logic [RAD_W-1:0]  rad_src  [NSTG];
   logic [REM_W-1:0]  rem_src  [NSTG];
   logic [ROOT_W-1:0] root_src [NSTG];
   logic [SIDE_W-1:0] side_src [NSTG];
   logic [RAD_W-1:0]  rad_in   [NSTG];
   logic [REM_W-1:0]  rem_in   [NSTG];
   logic [ROOT_W-1:0] root_in  [NSTG];
   logic [RAD_W-1:0]  rad_ff   [NSTG];
   logic [REM_W-1:0]  rem_ff   [NSTG];
   logic [ROOT_W-1:0] root_ff  [NSTG];
   logic [SIDE_W-1:0] side_ff  [NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= NSTG'({valid_ff, in_valid});
      end
   end

   for (genvar g = 0; g < NSTG; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign rad_src[g]  = in_rad;
         assign rem_src[g]  = '0;
         assign root_src[g] = '0;
         assign side_src[g] = in_side;
      end else begin : g_next
         assign rad_src[g]  = rad_ff[g-1];
         assign rem_src[g]  = rem_ff[g-1];
         assign root_src[g] = root_ff[g-1];
         assign side_src[g] = side_ff[g-1];
      end

      always_comb begin
         logic [RAD_W-1:0]  rd;
         logic [REM_W-1:0]  rm;
         logic [ROOT_W-1:0] rt;
         logic [REM_W-1:0]  tr;
         rd = rad_src[g];
         rm = rem_src[g];
         rt = root_src[g];
         for (int k = 0; k < SQRT_STEPS; k++) begin
            if (g * SQRT_STEPS + k < ROOT_W) begin
               rm = {rm[REM_W-3:0], rd[RAD_W-1 -: 2]};
               rd = rd << 2;
               tr = REM_W'({rt, 2'b01});
               if (rm >= tr) begin
                  rm = rm - tr;
                  rt = {rt[ROOT_W-2:0], 1'b1};
               end else begin
                  rt = {rt[ROOT_W-2:0], 1'b0};
               end
            end
         end
         rad_in[g]  = rd;
         rem_in[g]  = rm;
         root_in[g] = rt;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[g]  <= rad_in[g];
            rem_ff[g]  <= rem_in[g];
            root_ff[g] <= root_in[g];
            side_ff[g] <= side_src[g];
         end
      end
   end

   assign out_valid = valid_ff[NSTG-1];
   assign out_root  = root_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];

endmodule

`default_nettype wire

// ----- rtl/core/bal4_accum.sv -----
// ----------------------------------------------------------------------------
// bal4_accum
// Quadrature weighting of the four norms, rounding and saturation.
// Two register stages, the second being the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bal4_accum import bal4_pkg::*; #(
   parameter int NORM_W = 29
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire logic [NORM_W-1:0]   norm [NODES],
   output logic                     out_valid,
   output logic [LEN_W-1:0]         out_len,
   output logic                     out_sat
);

   localparam int NS_W = NORM_W + 1;
   localparam int P_W  = NS_W + QW_W;
   localparam int T_W  = (P_W + 1 > LEN_W + 1 + WFRAC) ? P_W + 1 : LEN_W + 1 + WFRAC;
   localparam int L_W  = T_W - WFRAC;

   logic             mid_valid_ff;
   logic             out_valid_ff;
   logic [P_W-1:0]   pin_ff;
   logic [P_W-1:0]   pout_ff;
   logic [T_W-1:0]   total;
   logic [L_W-1:0]   len;
   logic             sat;
   logic [LEN_W-1:0] len_in;
   logic [LEN_W-1:0] len_ff;
   logic             sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pin_ff  <= P_W'((NS_W'(norm[0]) + NS_W'(norm[1])) * QW_INNER);
         pout_ff <= P_W'((NS_W'(norm[2]) + NS_W'(norm[3])) * QW_OUTER);
      end
   end

   always_comb begin
      total  = T_W'(pin_ff) + T_W'(pout_ff) + (T_W'(1) << (WFRAC - 1));
      len    = total[T_W-1:WFRAC];
      sat    = (len >> LEN_W) != '0;
      len_in = sat ? '1 : len[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff <= len_in;
         sat_ff <= sat;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_len   = len_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bezier_arc_length_gauss4.sv -----
// ----------------------------------------------------------------------------
// bezier_arc_length_gauss4
// Cubic Bezier arc length by four-point Gauss-Legendre quadrature.
// ----------------------------------------------------------------------------
//  channel | dir | width                        | content
//  req_    | in  | tdata 12*COORD_WIDTH (bytes) | p0_x .. p3_z control points
//  rsp_    | out | tdata 32, tuser 1            | arc_length, saturated
//
//  One beat in per cycle while rsp_ is not stalled; the square root
//  pipeline is the longest part of the pipe.
//  Reset clears the valid bits only; no clearing pass.
//  A stall on rsp_ holds the whole pipeline, nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bezier_arc_length_gauss4_assert.svh"

module bezier_arc_length_gauss4 import bal4_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   output logic       req_tready,
   // p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z, zero pad
   input  wire logic [((POINTS*AXES*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   // arc_length
   output logic [LEN_W-1:0] rsp_tdata,
   // saturated
   output logic       rsp_tuser
);

   localparam int ROOT_W = root_w(COORD_WIDTH);
   localparam int S_W    = s_w(COORD_WIDTH);
   localparam int S_MAX  = s_max(COORD_WIDTH);
   localparam int NORM_W = norm_w(COORD_WIDTH);

   logic                          adv;
   logic signed [COORD_WIDTH-1:0] coord [POINTS][AXES];
   logic                          d_valid;
   logic [2*ROOT_W-1:0]           d_sum   [NODES];
   logic [S_W-1:0]                d_shift [NODES];
   logic [NODES-1:0]              r_valid;
   logic [ROOT_W-1:0]             r_root  [NODES];
   logic [S_W-1:0]                r_shift [NODES];
   logic [NORM_W-1:0]             norm    [NODES];

   // whole pipe advances unless the output register holds an untaken beat
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      for (int p = 0; p < POINTS; p++)
         for (int a = 0; a < AXES; a++)
            coord[p][a] = req_tdata[(p*AXES+a)*COORD_WIDTH +: COORD_WIDTH];
   end

   bal4_deriv #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_deriv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .coord     (coord),
      .out_valid (d_valid),
      .out_sum   (d_sum),
      .out_shift (d_shift)
   );

   for (genvar n = 0; n < NODES; n++) begin : g_node
      bal4_isqrt #(
         .ROOT_W (ROOT_W),
         .SIDE_W (S_W)
      ) u_isqrt (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (d_valid),
         .in_rad    (d_sum[n]),
         .in_side   (d_shift[n]),
         .out_valid (r_valid[n]),
         .out_root  (r_root[n]),
         .out_side  (r_shift[n])
      );

      assign norm[n] = NORM_W'({{S_MAX{1'b0}}, r_root[n]} << r_shift[n]);
   end

   bal4_accum #(
      .NORM_W (NORM_W)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (&r_valid),
      .norm      (norm),
      .out_valid (rsp_tvalid),
      .out_len   (rsp_tdata),
      .out_sat   (rsp_tuser)
   );

   `BAL4_ASSERT_IMPL(a_sat_is_max, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '1, "saturated beat without full-scale length")
   `BAL4_ASSERT_IMPL(a_empty_takes, clock, reset, !rsp_tvalid, req_tready, "input blocked with empty output register")
   `BAL4_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_tvalid, "result valid straight after reset")

endmodule

`default_nettype wire
